[hdl/gasp_pkg.sv]
// Shared types, constants and tables for the golden-angle spiral point generator.
`timescale 1ns / 1ps
`default_nettype none
package gasp_pkg;

    // Field widths
    localparam int IDX_W   = 13;
    localparam int SCALE_W = 16;
    localparam int OUT_W   = 24;

    // Rotation chain
    localparam int CORDIC_STAGES = 16;
    localparam int XW            = 33;          // Q30 vector component, signed
    localparam int ZW            = 34;          // residual angle, turns * 2^32, signed
    localparam int ANG_W         = 32;
    localparam int ATAN_W        = 30;
    localparam int ATAN_N        = 32;

    // Root chain: one result bit per step, radicand is index << 32
    localparam int FRAC_SH   = 32;
    localparam int ROOT_STEPS = 24;
    localparam int ROOT_TOP  = 2 * (ROOT_STEPS - 1);
    localparam int RW        = ROOT_TOP + 2;
    localparam int ROOT_W    = ROOT_STEPS;

    localparam int N_CELLS = (CORDIC_STAGES > ROOT_STEPS) ? CORDIC_STAGES : ROOT_STEPS;
    localparam int STAGE_W = 5;

    // Output scaling
    localparam int RAD_W     = 32;
    localparam int MAG_W     = XW;
    localparam int PROD_W    = MAG_W + RAD_W;
    localparam int RND_SHIFT = 38;

    localparam logic [ANG_W-1:0]   GOLDEN_TURN     = 32'd1640531527;
    localparam logic [XW-1:0]      CORDIC_INV_GAIN = 33'd652032874;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 16'd2560;
    localparam logic [OUT_W-1:0]   OUT_MAX         = 24'h7FFFFF;

    // atan(2^-j) as a fraction of a turn, scaled by 2^32
    localparam logic [ATAN_W-1:0] ATAN_TURN [ATAN_N] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    typedef struct packed {
        logic                 vld;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [RW-1:0]        rem;
        logic [RW-1:0]        res;
    } t_cell;

    // Trial bit of the root step at a given cell, zero past the last step
    function automatic logic [RW-1:0] root_bit(input logic [STAGE_W-1:0] stage);
        int sh;
        sh = ROOT_TOP - 2 * int'(stage);
        if (sh < 0) begin
            return '0;
        end
        return RW'(1) << sh;
    endfunction

endpackage
`default_nettype wire

[hdl/gasp_cell.sv]
// One cell of the chain: a rotation step (first CORDIC_STAGES cells only) and a square-root step, registered.
`timescale 1ns / 1ps
`default_nettype none
module gasp_cell import gasp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [STAGE_W-1:0] i_stage,
    input  wire t_cell              i_d,
    output t_cell                   o_q
);

    t_cell                r_q;
    t_cell                n_q;
    logic                 r_vld;
    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_y;
    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [ZW-1:0] w_z;
    logic signed [ZW-1:0] w_atan;
    logic [RW-1:0]        w_bit;
    logic [RW-1:0]        w_trial;
    logic                 w_cordic_on;
    logic                 w_root_on;

    always_comb begin
        w_x         = i_d.x;
        w_y         = i_d.y;
        w_z         = i_d.z;
        w_dx        = w_y >>> i_stage;
        w_dy        = w_x >>> i_stage;
        w_atan      = signed'(ZW'(ATAN_TURN[i_stage]));
        w_cordic_on = int'(i_stage) < CORDIC_STAGES;
        w_root_on   = int'(i_stage) < ROOT_STEPS;
        w_bit       = root_bit(i_stage);
        w_trial     = i_d.res + w_bit;

        n_q = i_d;
        if (w_cordic_on) begin
            // rotate toward zero residual angle
            if (w_z >= 0) begin
                n_q.x = w_x - w_dx;
                n_q.y = w_y + w_dy;
                n_q.z = w_z - w_atan;
            end else begin
                n_q.x = w_x + w_dx;
                n_q.y = w_y - w_dy;
                n_q.z = w_z + w_atan;
            end
        end
        if (w_root_on) begin
            if (i_d.rem >= w_trial) begin
                n_q.rem = i_d.rem - w_trial;
                n_q.res = (i_d.res >> 1) + w_bit;
            end else begin
                n_q.res = i_d.res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_comb begin
        o_q     = r_q;
        o_q.vld = r_vld;
    end

endmodule
`default_nettype wire

[hdl/gasp_scale.sv]
// Output pipeline: root rounding, radius scaling, trig times radius, rounding.
`timescale 1ns / 1ps
`default_nettype none
module gasp_scale import gasp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cell              i_d,
    input  wire logic [SCALE_W-1:0] i_scale,
    output logic                    o_valid,
    output logic [OUT_W-1:0]        o_x,
    output logic [OUT_W-1:0]        o_y
);

    localparam int RP_W = ROOT_W + SCALE_W;

    // stage A
    logic              r_va;
    logic [ROOT_W-1:0] r_s;
    logic [MAG_W-1:0]  r_magx_a;
    logic [MAG_W-1:0]  r_magy_a;
    logic              r_negx_a;
    logic              r_negy_a;
    logic [RW-1:0]     n_root;
    // stage B
    logic              r_vb;
    logic [RAD_W-1:0]  r_rad;
    logic [MAG_W-1:0]  r_magx_b;
    logic [MAG_W-1:0]  r_magy_b;
    logic              r_negx_b;
    logic              r_negy_b;
    logic [RP_W-1:0]   n_rad;
    // stage C
    logic              r_vc;
    logic [PROD_W-1:0] r_px;
    logic [PROD_W-1:0] r_py;
    logic              r_negx_c;
    logic              r_negy_c;
    // stage D
    logic              r_vd;
    logic [OUT_W-1:0]  r_x;
    logic [OUT_W-1:0]  r_y;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] neg_v;
        neg_v = -v;
        return (v < 0) ? MAG_W'(neg_v) : MAG_W'(v);
    endfunction

    // Round half away from zero to Q8, saturate, restore the sign
    function automatic logic [OUT_W-1:0] round_out(input logic [PROD_W-1:0] prod,
                                                   input logic neg);
        logic [PROD_W-1:0]           sum;
        logic [PROD_W-RND_SHIFT-1:0] p;
        logic [OUT_W-1:0]            mag;
        sum = prod + (PROD_W'(1) << (RND_SHIFT - 1));
        p   = sum[PROD_W-1:RND_SHIFT];
        if (p > (PROD_W-RND_SHIFT)'(OUT_MAX)) begin
            mag = OUT_MAX;
        end else begin
            mag = p[OUT_W-1:0];
        end
        return neg ? (-mag) : mag;
    endfunction

    always_comb begin
        n_root = i_d.res + RW'(i_d.rem > i_d.res);
        n_rad  = RP_W'(r_s) * RP_W'(i_scale) + RP_W'(128);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_d.vld;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s      <= n_root[ROOT_W-1:0];
        r_magx_a <= mag_of(i_d.x);
        r_magy_a <= mag_of(i_d.y);
        r_negx_a <= i_d.x < 0;
        r_negy_a <= i_d.y < 0;

        r_rad    <= n_rad[RAD_W+7:8];
        r_magx_b <= r_magx_a;
        r_magy_b <= r_magy_a;
        r_negx_b <= r_negx_a;
        r_negy_b <= r_negy_a;

        r_px     <= PROD_W'(r_magx_b) * PROD_W'(r_rad);
        r_py     <= PROD_W'(r_magy_b) * PROD_W'(r_rad);
        r_negx_c <= r_negx_b;
        r_negy_c <= r_negy_b;

        r_x      <= round_out(r_px, r_negx_c);
        r_y      <= round_out(r_py, r_negy_c);
    end

    assign o_valid = r_vd;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule
`default_nettype wire

[hdl/golden_angle_spiral_point.sv]
// Top level of the golden-angle spiral point generator.
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  -------------------------
//  item in   i_point_index[12:0]                          i_start & !o_busy
//  result    o_point_x[23:0], o_point_y[23:0]             o_valid, one cycle
//  config    i_cfg_wdata[15:0] (radius_scale)             i_cfg_we
//
// One item per cycle; o_busy is always low. The stages are angle multiply,
// quadrant fold, 24 chain cells set by the 24 root steps, then four output
// stages. Synchronous active-low reset clears the valid pipeline and loads
// radius_scale with 10.0. Results cannot be held.
`timescale 1ns / 1ps
`default_nettype none
module golden_angle_spiral_point import gasp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [IDX_W-1:0]   i_point_index,
    input  wire logic               i_cfg_we,
    input  wire logic [SCALE_W-1:0] i_cfg_wdata,
    output logic                    o_valid,
    output logic [OUT_W-1:0]        o_point_x,
    output logic [OUT_W-1:0]        o_point_y
);

    localparam int MUL_W = IDX_W + ANG_W;
    localparam logic signed [ZW-1:0] QTR  = ZW'(64'sd1 << 30);
    localparam logic signed [ZW-1:0] HALF = ZW'(64'sd1 << 31);

    logic [SCALE_W-1:0]   r_scale;
    logic                 r_v1;
    logic [ANG_W-1:0]     r_ang;
    logic [IDX_W-1:0]     r_idx1;
    logic                 r_v2;
    logic signed [ZW-1:0] r_z2;
    logic                 r_neg2;
    logic [IDX_W-1:0]     r_idx2;
    logic [MUL_W-1:0]     n_prod;
    logic signed [ZW-1:0] n_z;
    logic signed [ZW-1:0] n_zf;
    logic                 n_neg;
    logic                 w_accept;
    t_cell                w_chain [N_CELLS+1];

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_prod = MUL_W'(i_point_index) * MUL_W'(GOLDEN_TURN);
        // angle as a signed fraction of a turn, then fold into +-1/4 turn
        n_z    = signed'({{(ZW-ANG_W){r_ang[ANG_W-1]}}, r_ang});
        n_zf   = n_z;
        n_neg  = 1'b0;
        if (n_z > QTR) begin
            n_zf  = n_z - HALF;
            n_neg = 1'b1;
        end else if (n_z < -QTR) begin
            n_zf  = n_z + HALF;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang  <= n_prod[ANG_W-1:0];
        r_idx1 <= i_point_index;
        r_z2   <= n_zf;
        r_neg2 <= n_neg;
        r_idx2 <= r_idx1;
    end

    always_comb begin
        w_chain[0].vld = r_v2;
        w_chain[0].x   = r_neg2 ? -signed'(CORDIC_INV_GAIN) : signed'(CORDIC_INV_GAIN);
        w_chain[0].y   = '0;
        w_chain[0].z   = r_z2;
        w_chain[0].rem = RW'({r_idx2, {FRAC_SH{1'b0}}});
        w_chain[0].res = '0;
    end

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        gasp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_W'(g)),
            .i_d     (w_chain[g]),
            .o_q     (w_chain[g+1])
        );
    end

    gasp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_chain[N_CELLS]),
        .i_scale (r_scale),
        .o_valid (o_valid),
        .o_x     (o_point_x),
        .o_y     (o_point_y)
    );

endmodule
`default_nettype wire

[test/spiral_point_checker.sv]
// Checker for the spiral point generator: predicts each point and compares the results.
`timescale 1ns / 1ps
module spiral_point_checker import gasp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic [IDX_W-1:0]   i_point_index,
    input  wire logic               i_cfg_we,
    input  wire logic [SCALE_W-1:0] i_cfg_wdata,
    input  wire logic               i_valid,
    input  wire logic [OUT_W-1:0]   i_point_x,
    input  wire logic [OUT_W-1:0]   i_point_y,
    output int                      o_mismatches,
    output int                      o_pending
);

    localparam logic [31:0]     GOLDEN_STEP   = 32'd1640531527;
    localparam longint          START_X       = 64'sd652032874;
    localparam longint          QUARTER_TURN  = 64'sd1073741824;
    localparam longint          HALF_TURN     = 64'sd2147483648;
    localparam int              ROT_STAGES    = 16;
    localparam int              ROOT_ITERS    = 24;
    localparam logic [63:0]     Q8_LIMIT      = 64'd8388607;
    localparam logic [15:0]     SCALE_DEFAULT = 16'd2560;

    longint           atan_lut [ROT_STAGES];
    logic [15:0]      scale_shadow;
    logic [OUT_W-1:0] want_x [$];
    logic [OUT_W-1:0] want_y [$];
    int               mismatches;

    initial begin
        atan_lut = '{536870912, 316933406, 167458907, 85004756,
                     42667331,  21354465,  10679838,  5340245,
                     2670163,   1335087,   667544,    333772,
                     166886,    83443,     41722,     20861};
        mismatches   = 0;
        scale_shadow = SCALE_DEFAULT;
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Rescale a Q30 trig value by a Q16 radius to Q8, rounding half away from zero.
    function automatic logic [OUT_W-1:0] trig_times_radius(input longint trig,
                                                           input logic [63:0] radius);
        logic [63:0] mag;
        logic [63:0] prod;
        mag  = (trig < 0) ? -trig : trig;
        prod = (mag * radius + (64'd1 << 37)) >> 38;
        if (prod > Q8_LIMIT) begin
            prod = Q8_LIMIT;
        end
        return (trig < 0) ? OUT_W'(-prod) : OUT_W'(prod);
    endfunction

    task automatic spiral_point(input logic [IDX_W-1:0] idx, input logic [15:0] k,
                                output logic [OUT_W-1:0] px, output logic [OUT_W-1:0] py);
        logic [31:0] turn;
        longint      z;
        longint      cx;
        longint      cy;
        longint      dx;
        longint      dy;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] radius;
        turn = 32'(idx) * GOLDEN_STEP;
        z    = $signed(turn);
        cx   = START_X;
        cy   = 0;
        // fold the back half-plane onto the front one
        if (z > QUARTER_TURN) begin
            z  = z - HALF_TURN;
            cx = -cx;
        end else if (z < -QUARTER_TURN) begin
            z  = z + HALF_TURN;
            cx = -cx;
        end
        for (int j = 0; j < ROT_STAGES; j++) begin
            dx = cy >>> j;
            dy = cx >>> j;
            if (z >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - atan_lut[j];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + atan_lut[j];
            end
        end
        // bitwise root of idx * 2^32, rounded to nearest
        rem   = {19'd0, idx, 32'd0};
        root  = 64'd0;
        trial = 64'd1 << 46;
        for (int j = 0; j < ROOT_ITERS; j++) begin
            if (rem >= root + trial) begin
                rem  = rem - (root + trial);
                root = (root >> 1) + trial;
            end else begin
                root = root >> 1;
            end
            trial = trial >> 2;
        end
        if (rem > root) begin
            root = root + 64'd1;
        end
        radius = (root * {48'd0, k} + 64'd128) >> 8;
        px = trig_times_radius(cx, radius);
        py = trig_times_radius(cy, radius);
    endtask

    always @(posedge i_clk) begin : track
        logic [OUT_W-1:0] ex;
        logic [OUT_W-1:0] ey;
        if (!i_rst_n) begin
            want_x.delete();
            want_y.delete();
            scale_shadow = SCALE_DEFAULT;
        end else begin
            if (i_valid) begin
                if (want_x.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected point x=%0d y=%0d", $realtime,
                                 $signed(i_point_x), $signed(i_point_y));
                    end
                end else begin
                    ex = want_x.pop_front();
                    ey = want_y.pop_front();
                    if (ex !== i_point_x || ey !== i_point_y) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: point mismatch x exp %0d got %0d, y exp %0d got %0d",
                                     $realtime, $signed(ex), $signed(i_point_x),
                                     $signed(ey), $signed(i_point_y));
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                spiral_point(i_point_index, scale_shadow, ex, ey);
                want_x.push_back(ex);
                want_y.push_back(ey);
            end
            if (i_cfg_we) begin
                scale_shadow = i_cfg_wdata;
            end
        end
        o_pending    <= want_x.size();
        o_mismatches <= mismatches;
    end

endmodule

[test/tb_golden_angle_spiral_point.sv]
// Testbench top for the golden-angle spiral point generator: stimulus and verdict.
`timescale 1ns / 1ps
module tb_golden_angle_spiral_point;
    import gasp_pkg::*;

    localparam int LATENCY     = N_CELLS + 6;
    localparam int DRAIN_LIMIT = 10000;
    localparam int PHASE_ITEMS = 250;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [IDX_W-1:0]   i_point_index;
    logic               i_cfg_we;
    logic [SCALE_W-1:0] i_cfg_wdata;
    logic               o_valid;
    logic [OUT_W-1:0]   o_point_x;
    logic [OUT_W-1:0]   o_point_y;
    int                 mismatches;
    int                 pending;

    golden_angle_spiral_point uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_point_index (i_point_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y)
    );

    spiral_point_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_point_index (i_point_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (o_valid),
        .i_point_x     (o_point_x),
        .i_point_y     (o_point_y),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #1000000;
        $display("golden_angle_spiral_point regression: fail");
        $finish;
    end

    // Offer one item, hold it until taken; optionally idle a few cycles first.
    task automatic send_point(input logic [IDX_W-1:0] idx, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(99) < 3) begin
            i_start <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_point_index <= idx;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Drain the pipeline, then load a new radius scale.
    task automatic program_scale(input logic [SCALE_W-1:0] k);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) begin
            return '0;
        end else if (roll < 6) begin
            return '1;
        end else if (roll < 30) begin
            return IDX_W'($urandom_range(1, 4096));
        end
        return IDX_W'($urandom_range(0, 8191));
    endfunction

    initial begin : stim
        int               waited;
        logic [SCALE_W-1:0] k;
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_point_index <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners at the reset scale: zero index, ends of the range, past 4096
        send_point(13'd0, 1'b0);    send_point(13'd1, 1'b0);
        send_point(13'd2, 1'b0);    send_point(13'd3, 1'b0);
        send_point(13'd4, 1'b0);    send_point(13'd5, 1'b0);
        send_point(13'd89, 1'b0);   send_point(13'd144, 1'b0);
        send_point(13'd233, 1'b0);  send_point(13'd987, 1'b0);
        send_point(13'd1024, 1'b0); send_point(13'd2048, 1'b0);
        send_point(13'd2730, 1'b0); send_point(13'd4095, 1'b0);
        send_point(13'd4096, 1'b0); send_point(13'd4097, 1'b0);
        send_point(13'd5461, 1'b0); send_point(13'd8190, 1'b0);
        send_point(13'd8191, 1'b0); send_point(13'd0, 1'b0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       k = 16'd0;
                1:       k = 16'hFFFF;
                2:       k = 16'd1;
                3:       k = 16'd256;
                4:       k = 16'd2560;
                default: k = SCALE_W'($urandom_range(0, 65535));
            endcase
            program_scale(k);
            // one phase runs flat out with no gaps
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_point(pick_index(), ph != 3);
            end
        end

        i_start <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY) @(posedge i_clk);
        if (pending == 0 && mismatches == 0) begin
            $display("golden_angle_spiral_point regression: pass");
        end else begin
            $display("golden_angle_spiral_point regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/gasp_pkg.sv
hdl/gasp_cell.sv
hdl/gasp_scale.sv
hdl/golden_angle_spiral_point.sv
test/spiral_point_checker.sv
test/tb_golden_angle_spiral_point.sv
